// ===== src/flcg_pkg.sv =====
package flcg_pkg;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint WIN_A   = 64'sd579820585;
    localparam longint WIN_B   = 64'sd493921239;
    localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;

    localparam logic [1:0] CFG_TAP_ORDER = 2'd0;
    localparam logic [1:0] CFG_CUTOFF    = 2'd1;
    localparam logic [1:0] CFG_DELAY     = 2'd2;

    localparam logic [5:0]  RST_TAP_ORDER = 6'd31;
    localparam logic [15:0] RST_CUTOFF    = 16'd16384;
    localparam logic [12:0] RST_DELAY     = 13'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_CHECK,
        S_W_INIT,
        S_W_STEP,
        S_W_WIN,
        S_SUM,
        S_DIV_SUM,
        S_W_SUM,
        S_MUL_WIN,
        S_WCALC,
        S_MUL_OUT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DS_INIT,
        DS_STEP,
        DS_WIN,
        DS_SUM
    } t_dsel;

    typedef enum logic {
        MS_WIN,
        MS_OUT
    } t_msel;

    typedef struct packed {
        logic  accept;
        logic  setup;
        logic  div_start;
        t_dsel div_sel;
        logic  cap_init;
        logic  cap_step;
        logic  cap_win;
        logic  sum_en;
        logic  cap_h;
        logic  mul_en;
        t_msel mul_sel;
        logic  cap_w;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic idx_bad;
        logic last_term;
        logic out_free;
    } t_sts;

    // quarter-wave cosine entry, Q30, 8-term Taylor series
    function automatic logic signed [31:0] cos_entry(input int r, input int pb);
        logic [63:0] th;
        longint      x2;
        longint      acc;
        th  = (64'(r) * TWO_PI_Q29) >> (pb - 1);
        x2  = longint'((th * th) >> 30);
        acc = ONE_Q30;
        acc = ONE_Q30 - ((x2 * acc) / ONE_Q30) / 64'sd182;
        acc = ONE_Q30 - ((x2 * acc) / ONE_Q30) / 64'sd132;
        acc = ONE_Q30 - ((x2 * acc) / ONE_Q30) / 64'sd90;
        acc = ONE_Q30 - ((x2 * acc) / ONE_Q30) / 64'sd56;
        acc = ONE_Q30 - ((x2 * acc) / ONE_Q30) / 64'sd30;
        acc = ONE_Q30 - ((x2 * acc) / ONE_Q30) / 64'sd12;
        acc = ONE_Q30 - ((x2 * acc) / ONE_Q30) / 64'sd2;
        if (r == 0) begin
            acc = ONE_Q30;
        end
        if (r == (1 << (pb - 2))) begin
            acc = 0;
        end
        return 32'(acc);
    endfunction

endpackage

// ===== src/flcg_div.sv =====
module flcg_div #(
    parameter int DW = 39,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   trial;
    logic          ge;
    logic [VW-1:0] n_rem;
    logic [DW-1:0] n_quo;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        ge    = trial >= {1'b0, r_dvs};
        n_rem = ge ? VW'(trial - {1'b0, r_dvs}) : VW'(trial);
        n_quo = {r_quo[DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

// ===== src/flcg_cos_rom.sv =====
module flcg_cos_rom #(
    parameter int PHASE_BITS = 10
) (
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic signed [31:0]    o_cos
);

    localparam int QUARTER = 1 << (PHASE_BITS - 2);

    logic signed [31:0]     tab [QUARTER+1];
    logic [1:0]             quad;
    logic [PHASE_BITS-3:0]  rem;
    logic [PHASE_BITS-2:0]  addr;
    logic signed [31:0]     val;

    for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
        assign tab[g] = flcg_pkg::cos_entry(g, PHASE_BITS);
    end

    always_comb begin
        quad  = i_phase[PHASE_BITS-1 -: 2];
        rem   = i_phase[PHASE_BITS-3:0];
        addr  = quad[0] ? ((PHASE_BITS-1)'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
        val   = tab[addr];
        o_cos = (quad[1] ^ quad[0]) ? -val : val;
    end

endmodule

// ===== src/flcg_dp.sv =====
module flcg_dp #(
    parameter int MAX_TAPS   = 64,
    parameter int PHASE_BITS = 10,
    parameter int COEF_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  flcg_pkg::t_cmd        i_cmd,
    output flcg_pkg::t_sts        o_sts,
    input  logic [5:0]            i_tap_index,
    input  logic [5:0]            i_order,
    input  logic [15:0]           i_cutoff,
    input  logic signed [12:0]    i_delay,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [COEF_BITS-1:0]  o_coef,
    output logic                  o_index_valid
);

    localparam int CAP  = (MAX_TAPS > 64) ? 64 : MAX_TAPS;
    localparam int PB   = PHASE_BITS;
    localparam int OFS  = PB + 13;
    localparam int DIVW = (PB + 29 > 37) ? PB + 29 : 37;
    localparam int XW   = DIVW + 1;
    localparam int VW   = 16;
    localparam int SW   = 38;

    // item registers
    logic [5:0]            r_t;
    logic [6:0]            r_nt;
    logic [5:0]            r_n;
    logic [5:0]            r_i;
    logic [5:0]            r_hi;
    logic signed [7:0]     r_lmc;
    logic signed [15:0]    r_arg;
    logic [PB-1:0]         r_q;
    logic [VW-1:0]         r_r;
    logic [PB-1:0]         r_qa;
    logic [VW-1:0]         r_ra;
    logic [PB-1:0]         r_qw;
    logic signed [SW-1:0]  r_sum;
    logic signed [31:0]    r_h;
    logic signed [31:0]    r_w;
    logic signed [63:0]    r_prod;
    logic [COEF_BITS-1:0]  r_coef;
    logic                  r_ivld;
    logic                  r_ovld;

    // setup
    logic [6:0]            nt_full;
    logic [6:0]            nt_c;
    logic [5:0]            n_c;
    logic [21:0]           kc_prod;
    logic [4:0]            kc;
    logic signed [7:0]     half_n;
    logic signed [7:0]     half_nt;
    logic signed [7:0]     lo_s;
    logic signed [7:0]     hi_s;
    logic [5:0]            lo_c;
    logic [5:0]            hi_c;
    logic signed [7:0]     lmc;
    logic signed [15:0]    arg;

    always_comb begin
        nt_full = 7'(i_order) + 7'd1;
        nt_c    = (nt_full > 7'(CAP)) ? 7'(CAP) : nt_full;
        n_c     = 6'(nt_c - 7'd1);
        kc_prod = 22'(n_c) * 22'(i_cutoff);
        kc      = 5'(kc_prod >> 17);
        half_n  = 8'(n_c >> 1);
        half_nt = 8'(nt_c >> 1);
        if (nt_c[0]) begin
            lo_s = half_n - 8'(kc);
            hi_s = half_n + 8'(kc);
        end else begin
            lo_s = half_nt - 8'(kc) - 8'sd1;
            hi_s = half_nt + 8'(kc) - 8'sd1;
        end
        lo_c = (lo_s < 8'sd0) ? 6'd0 : lo_s[5:0];
        hi_c = (hi_s > $signed({2'b00, n_c})) ? n_c : hi_s[5:0];
        lmc  = $signed({2'b00, lo_c}) - half_nt;
        arg  = 16'({r_t, 8'b0}) - 16'({n_c, 7'b0}) - 16'(i_delay);
    end

    // divider operands
    logic [15:0]           div_d;
    logic [14:0]           den;
    logic signed [23:0]    num_init;
    logic [XW-1:0]         offs;
    logic [SW-1:0]         sum_abs;
    logic [XW-1:0]         xdiv;
    logic [VW-1:0]         divisor;
    logic                  div_done;
    logic [DIVW-1:0]       div_quot;
    logic [VW-1:0]         div_rem;

    always_comb begin
        div_d    = {r_nt, 9'b0};
        den      = {r_nt, 8'b0};
        num_init = 24'(r_lmc) * 24'(r_arg);
        offs     = XW'(div_d) << OFS;
        sum_abs  = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
        case (i_cmd.div_sel)
            flcg_pkg::DS_INIT: xdiv = (XW'(num_init) << (PB + 1)) + XW'(den) + offs;
            flcg_pkg::DS_STEP: xdiv = (XW'(r_arg) << (PB + 1)) + offs;
            flcg_pkg::DS_WIN:  xdiv = (XW'(r_t) << (PB + 9)) + XW'(den);
            flcg_pkg::DS_SUM:  xdiv = XW'(sum_abs);
            default:           xdiv = '0;
        endcase
        divisor = (i_cmd.div_sel == flcg_pkg::DS_SUM) ? VW'(r_nt) : div_d;
    end

    flcg_div #(
        .DW (DIVW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (xdiv[DIVW-1:0]),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // cosine table
    logic [PB-1:0]         cos_idx;
    logic signed [31:0]    cos_v;

    assign cos_idx = i_cmd.sum_en ? r_q : r_qw;

    flcg_cos_rom #(
        .PHASE_BITS (PB)
    ) u_cos (
        .i_phase (cos_idx),
        .o_cos   (cos_v)
    );

    // term phase stepping
    logic [VW:0]           rs;
    logic                  wrap;

    always_comb begin
        rs   = {1'b0, r_r} + {1'b0, r_ra};
        wrap = rs >= {1'b0, div_d};
    end

    // shared multiplier and output math
    logic signed [31:0]    ma;
    logic signed [31:0]    mb;
    logic signed [31:0]    hq;
    logic signed [63:0]    prod_tr;
    logic signed [63:0]    rnd;
    logic signed [63:0]    lim;
    logic signed [63:0]    sat;

    always_comb begin
        case (i_cmd.mul_sel)
            flcg_pkg::MS_WIN: begin
                ma = 32'(flcg_pkg::WIN_B);
                mb = cos_v;
            end
            flcg_pkg::MS_OUT: begin
                ma = r_h;
                mb = r_w;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        hq      = $signed(div_quot[31:0]);
        prod_tr = r_prod[63] ? ((r_prod + 64'sd1073741823) >>> 30) : (r_prod >>> 30);
        rnd     = (r_prod + (64'sd1 <<< (60 - COEF_BITS))) >>> (61 - COEF_BITS);
        lim     = (64'sd1 <<< (COEF_BITS - 1)) - 64'sd1;
        if (rnd > lim) begin
            sat = lim;
        end else if (rnd < -lim - 64'sd1) begin
            sat = -lim - 64'sd1;
        end else begin
            sat = rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_t <= i_tap_index;
        end
        if (i_cmd.setup) begin
            r_nt  <= nt_c;
            r_n   <= n_c;
            r_i   <= lo_c;
            r_hi  <= hi_c;
            r_lmc <= lmc;
            r_arg <= arg;
            r_sum <= '0;
        end
        if (i_cmd.cap_init) begin
            r_q <= div_quot[PB-1:0];
            r_r <= div_rem;
        end
        if (i_cmd.cap_step) begin
            r_qa <= div_quot[PB-1:0];
            r_ra <= div_rem;
        end
        if (i_cmd.cap_win) begin
            r_qw <= div_quot[PB-1:0];
        end
        if (i_cmd.sum_en) begin
            r_sum <= r_sum + SW'(cos_v);
            r_q   <= r_q + r_qa + PB'(wrap);
            r_r   <= wrap ? VW'(rs - {1'b0, div_d}) : rs[VW-1:0];
            r_i   <= r_i + 6'd1;
        end
        if (i_cmd.cap_h) begin
            r_h <= r_sum[SW-1] ? -hq : hq;
        end
        if (i_cmd.mul_en) begin
            r_prod <= 64'(ma) * 64'(mb);
        end
        if (i_cmd.cap_w) begin
            r_w <= 32'(flcg_pkg::WIN_A - prod_tr);
        end
        if (i_cmd.out_load) begin
            r_coef <= o_sts.idx_bad ? '0 : sat[COEF_BITS-1:0];
            r_ivld <= !o_sts.idx_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_m_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_comb begin
        o_sts.div_done  = div_done;
        o_sts.idx_bad   = r_t > r_n;
        o_sts.last_term = r_i == r_hi;
        o_sts.out_free  = !r_ovld || i_m_ready;
    end

    assign o_m_valid     = r_ovld;
    assign o_coef        = r_coef;
    assign o_index_valid = r_ivld;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum_en |=> (r_r < div_d))
        else $error("phase remainder out of range");

endmodule

// ===== src/flcg_ctrl.sv =====
module flcg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  flcg_pkg::t_sts i_sts,
    output flcg_pkg::t_cmd o_cmd
);

    flcg_pkg::t_state r_state;
    flcg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= flcg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            flcg_pkg::S_IDLE: begin
                if (i_in_valid) n_state = flcg_pkg::S_SETUP;
            end
            flcg_pkg::S_SETUP:   n_state = flcg_pkg::S_CHECK;
            flcg_pkg::S_CHECK: begin
                n_state = i_sts.idx_bad ? flcg_pkg::S_OUT : flcg_pkg::S_W_INIT;
            end
            flcg_pkg::S_W_INIT: begin
                if (i_sts.div_done) n_state = flcg_pkg::S_W_STEP;
            end
            flcg_pkg::S_W_STEP: begin
                if (i_sts.div_done) n_state = flcg_pkg::S_W_WIN;
            end
            flcg_pkg::S_W_WIN: begin
                if (i_sts.div_done) n_state = flcg_pkg::S_SUM;
            end
            flcg_pkg::S_SUM: begin
                if (i_sts.last_term) n_state = flcg_pkg::S_DIV_SUM;
            end
            flcg_pkg::S_DIV_SUM: n_state = flcg_pkg::S_W_SUM;
            flcg_pkg::S_W_SUM: begin
                if (i_sts.div_done) n_state = flcg_pkg::S_MUL_WIN;
            end
            flcg_pkg::S_MUL_WIN: n_state = flcg_pkg::S_WCALC;
            flcg_pkg::S_WCALC:   n_state = flcg_pkg::S_MUL_OUT;
            flcg_pkg::S_MUL_OUT: n_state = flcg_pkg::S_OUT;
            flcg_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = flcg_pkg::S_IDLE;
            end
            default: n_state = flcg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            flcg_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            flcg_pkg::S_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            flcg_pkg::S_CHECK: begin
                o_cmd.div_start = !i_sts.idx_bad;
                o_cmd.div_sel   = flcg_pkg::DS_INIT;
            end
            flcg_pkg::S_W_INIT: begin
                o_cmd.cap_init  = i_sts.div_done;
                o_cmd.div_start = i_sts.div_done;
                o_cmd.div_sel   = flcg_pkg::DS_STEP;
            end
            flcg_pkg::S_W_STEP: begin
                o_cmd.cap_step  = i_sts.div_done;
                o_cmd.div_start = i_sts.div_done;
                o_cmd.div_sel   = flcg_pkg::DS_WIN;
            end
            flcg_pkg::S_W_WIN: begin
                o_cmd.cap_win = i_sts.div_done;
            end
            flcg_pkg::S_SUM: begin
                o_cmd.sum_en = 1'b1;
            end
            flcg_pkg::S_DIV_SUM: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = flcg_pkg::DS_SUM;
            end
            flcg_pkg::S_W_SUM: begin
                o_cmd.div_sel = flcg_pkg::DS_SUM;
                o_cmd.cap_h   = i_sts.div_done;
            end
            flcg_pkg::S_MUL_WIN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = flcg_pkg::MS_WIN;
            end
            flcg_pkg::S_WCALC: begin
                o_cmd.cap_w = 1'b1;
            end
            flcg_pkg::S_MUL_OUT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = flcg_pkg::MS_OUT;
            end
            flcg_pkg::S_OUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == flcg_pkg::S_SUM && !i_sts.last_term) |=> (r_state == flcg_pkg::S_SUM))
        else $error("term loop left early");

    a_bad_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == flcg_pkg::S_CHECK && i_sts.idx_bad) |=> (r_state == flcg_pkg::S_OUT))
        else $error("out-of-range index not short-cut");

endmodule

// ===== src/fir_lowpass_coefficient_generator_top.sv =====
// Hamming-windowed low-pass FIR coefficient generator (frequency sampling).
// Slave stream: one beat carries a tap index in s_axis_tdata[5:0].
// Master stream: one beat per request, coefficient (signed Q1.(COEF_BITS-1))
// in m_axis_tdata, index-valid flag in m_axis_tuser[0].
// Config channel: i_cfg_index 0 = tap order, 1 = cutoff (Q0.16),
// 2 = extra delay (signed Q5.8); always ready, write only while idle.
// One request at a time. An index beyond the order goes straight to the output.
// A valid index runs four divides on the iterative divider of length D =
// max(PHASE_BITS+29, 37) bits (one quotient bit a cycle: first phase, phase
// step, window phase, final divide by N) and sums the passband bins, one
// table lookup per cycle.
// A finished result sits in the output register; the next request is taken
// while it waits, and its result is held back until the receiver takes the
// earlier one. Reset restores order 31, cutoff 0.25, delay 0.
module fir_lowpass_coefficient_generator_top #(
    parameter int MAX_TAPS   = 64,
    parameter int PHASE_BITS = 10,
    parameter int COEF_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [5:0] tap_index
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((COEF_BITS+7)/8)*8-1:0]      m_axis_tdata,  // coefficient
    output logic [0:0]                          m_axis_tuser,  // [0] index_valid
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);

    localparam int OUTW = ((COEF_BITS + 7) / 8) * 8;

    logic [5:0]            r_order;
    logic [15:0]           r_cutoff;
    logic signed [12:0]    r_delay;

    flcg_pkg::t_cmd        cmd;
    flcg_pkg::t_sts        sts;
    logic [COEF_BITS-1:0]  coef;
    logic                  ivld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order  <= flcg_pkg::RST_TAP_ORDER;
            r_cutoff <= flcg_pkg::RST_CUTOFF;
            r_delay  <= flcg_pkg::RST_DELAY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                flcg_pkg::CFG_TAP_ORDER: r_order  <= i_cfg_data[5:0];
                flcg_pkg::CFG_CUTOFF:    r_cutoff <= i_cfg_data;
                flcg_pkg::CFG_DELAY:     r_delay  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    flcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    flcg_dp #(
        .MAX_TAPS   (MAX_TAPS),
        .PHASE_BITS (PHASE_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_tap_index   (s_axis_tdata[5:0]),
        .i_order       (r_order),
        .i_cutoff      (r_cutoff),
        .i_delay       (r_delay),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_coef        (coef),
        .o_index_valid (ivld)
    );

    assign m_axis_tdata = OUTW'(coef);
    assign m_axis_tuser = ivld;

endmodule

// ===== dv/flcg_checker.sv =====
module flcg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [7:0]  i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [15:0] i_m_data,
    input  logic [0:0]  i_m_user,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_err_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] coef;
        logic               idx_ok;
    } t_coef_beat;

    logic signed [31:0] quarter_cos [0:256];
    logic [5:0]         order_q;
    logic [15:0]        cutoff_q;
    logic [12:0]        delay_q;
    t_coef_beat         expected_coefs [$];

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint cos_at(input longint idx);
        int q;
        int r;
        q = int'((idx >> 8) & 3);
        r = int'(idx & 255);
        case (q)
            0: return quarter_cos[r];
            1: return -longint'(quarter_cos[256 - r]);
            2: return -longint'(quarter_cos[r]);
            default: return quarter_cos[256 - r];
        endcase
    endfunction

    // nearest step on a 1024-per-turn grid, wrapped
    function automatic longint turn_step(input longint num, input longint den);
        return floor_quot(num * 2048 + den, 2 * den) & 1023;
    endfunction

    function automatic t_coef_beat predict_coefficient(input logic [5:0] tap);
        t_coef_beat rv;
        longint nt, n, t, c, kc, lo, hi, d, arg, den, acc, h, w, res;
        nt = longint'(order_q) + 1;
        n  = nt - 1;
        t  = longint'(tap);
        rv.coef   = '0;
        rv.idx_ok = 1'b0;
        if (t > n) begin
            return rv;
        end
        c  = nt / 2;
        kc = (n * longint'(cutoff_q)) >>> 17;
        if (nt % 2 != 0) begin
            lo = n / 2 - kc;
            hi = n / 2 + kc;
        end else begin
            lo = nt / 2 - kc - 1;
            hi = nt / 2 + kc - 1;
        end
        if (lo < 0) lo = 0;
        if (hi > nt - 1) hi = nt - 1;
        d   = longint'($signed(delay_q));
        arg = t * 256 - n * 128 - d;
        den = 256 * nt;
        acc = 0;
        for (longint i = lo; i <= hi; i++) begin
            acc += cos_at(turn_step((i - c) * arg, den));
        end
        h   = acc / nt;
        w   = flcg_pkg::WIN_A
              - (flcg_pkg::WIN_B * cos_at(turn_step(t * 256, den))) / flcg_pkg::ONE_Q30;
        res = floor_quot(h * w + (longint'(1) << 44), longint'(1) << 45);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        rv.coef   = 16'(res);
        rv.idx_ok = 1'b1;
        return rv;
    endfunction

    initial begin
        logic [63:0] th;
        longint      x2, acc;
        for (int r = 0; r <= 256; r++) begin
            th  = (64'(r) * flcg_pkg::TWO_PI_Q29) >> 9;
            x2  = longint'((th * th) >> 30);
            acc = flcg_pkg::ONE_Q30;
            for (int k = 7; k >= 1; k--) begin
                acc = flcg_pkg::ONE_Q30 - ((x2 * acc) / flcg_pkg::ONE_Q30)
                      / longint'((2 * k) * (2 * k - 1));
            end
            quarter_cos[r] = 32'(acc);
        end
        quarter_cos[0]   = 32'(flcg_pkg::ONE_Q30);
        quarter_cos[256] = '0;
    end

    always @(posedge i_clk) begin
        t_coef_beat exp_b;
        if (!i_rst_n) begin
            order_q  <= flcg_pkg::RST_TAP_ORDER;
            cutoff_q <= flcg_pkg::RST_CUTOFF;
            delay_q  <= flcg_pkg::RST_DELAY;
            expected_coefs.delete();
            o_err_count <= 0;
            o_pending   <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    flcg_pkg::CFG_TAP_ORDER: order_q  <= i_cfg_data[5:0];
                    flcg_pkg::CFG_CUTOFF:    cutoff_q <= i_cfg_data;
                    flcg_pkg::CFG_DELAY:     delay_q  <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) begin
                expected_coefs.push_back(predict_coefficient(i_s_data[5:0]));
            end
            if (i_m_valid && i_m_ready) begin
                if (expected_coefs.size() == 0) begin
                    $error("unexpected beat: coefficient %0d index_valid %0d",
                           $signed(i_m_data), i_m_user[0]);
                    o_err_count <= o_err_count + 1;
                end else begin
                    exp_b = expected_coefs.pop_front();
                    if (exp_b.coef !== i_m_data || exp_b.idx_ok !== i_m_user[0]) begin
                        o_err_count <= o_err_count + 1;
                    end
                    if (exp_b.coef !== i_m_data) begin
                        $error("coefficient: expected %0d actual %0d",
                               exp_b.coef, $signed(i_m_data));
                    end
                    if (exp_b.idx_ok !== i_m_user[0]) begin
                        $error("index_valid: expected %0d actual %0d",
                               exp_b.idx_ok, i_m_user[0]);
                    end
                end
            end
            o_pending <= expected_coefs.size();
        end
    end
endmodule

// ===== dv/fir_lowpass_coefficient_generator_top_tb.sv =====
module fir_lowpass_coefficient_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    int          err_count;
    int          pending;
    int          burst_left = 0;
    logic [5:0]  cur_order = flcg_pkg::RST_TAP_ORDER;

    fir_lowpass_coefficient_generator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    flcg_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata), .i_m_user(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_err_count(err_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

    // receiver: alternating ready and stall runs, stalls occasionally long
    always @(posedge i_clk) begin
        static int  run_left = 0;
        static bit  rdy = 1'b0;
        if (run_left == 0) begin
            rdy = !rdy;
            if (rdy) begin
                run_left = $urandom_range(1, 40);
            end else if ($urandom_range(0, 5) == 0) begin
                run_left = $urandom_range(1, 200);
            end else begin
                run_left = $urandom_range(1, 8);
            end
        end
        run_left--;
        m_axis_tready <= rdy;
    end

    task automatic send_tap(input logic [5:0] tap);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {$urandom_range(0, 3) == 0 ? 2'($urandom) : 2'b00, tap};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // leaves valid high; caller lowers it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == flcg_pkg::CFG_TAP_ORDER) begin
            cur_order = val[5:0];
        end
    endtask

    task automatic set_all(input logic [15:0] ord, input logic [15:0] cut,
                           input logic [15:0] dly);
        drain();
        write_reg(flcg_pkg::CFG_TAP_ORDER, ord);
        write_reg(flcg_pkg::CFG_CUTOFF, cut);
        write_reg(flcg_pkg::CFG_DELAY, dly);
        write_reg(CFG_UNUSED, 16'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_tap();
        if ($urandom_range(0, 9) == 0) begin
            return 6'($urandom);
        end
        return 6'($urandom_range(0, cur_order));
    endfunction

    initial begin
        logic [15:0] ord, cut, dly;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: ends, middle, beyond order, top index
        send_tap(6'd0);
        send_tap(6'd31);
        send_tap(6'd15);
        send_tap(6'd32);
        send_tap(6'd63);
        set_all(16'hFFC0, 16'd0, 16'd0);          // single tap
        send_tap(6'd0);
        send_tap(6'd1);
        set_all(16'd63, 16'hFFFF, 16'h1000);      // full width, max cutoff, most negative delay
        send_tap(6'd0);
        send_tap(6'd63);
        send_tap(6'd32);
        set_all(16'd62, 16'd0, 16'hEFFF);         // odd tap count, most positive delay
        send_tap(6'd0);
        send_tap(6'd31);
        send_tap(6'd62);
        send_tap(6'd63);
        set_all(16'd1, 16'hFFFF, 16'h0080);
        send_tap(6'd0);
        send_tap(6'd1);
        send_tap(6'd2);
        set_all(16'd2, 16'd65535, 16'h1FFF);
        send_tap(6'd1);
        send_tap(6'd2);

        for (int ph = 0; ph < 14; ph++) begin
            case (ph % 5)
                0: ord = 16'($urandom_range(0, 7)) | 16'($urandom) & 16'hFFC0;
                1: ord = 16'd63;
                default: ord = 16'($urandom);
            endcase
            case (ph % 4)
                0: cut = 16'd0;
                1: cut = 16'hFFFF;
                default: cut = 16'($urandom);
            endcase
            case (ph % 3)
                0: dly = 16'h1000 | 16'($urandom) & 16'hE000;
                1: dly = 16'h0FFF;
                default: dly = 16'($urandom);
            endcase
            set_all(ord, cut, dly);
            for (int k = 0; k < 102; k++) begin
                send_tap(pick_tap());
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
